FILE: rtl/pcsp_pkg.sv
// Package for the pad/card serial port: register offsets, bit positions,
// request and device operation codes, and the slot selection type.
// No dependencies.
package pcsp_pkg;

  // Request types
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Register byte offsets
  localparam logic [3:0] OFF_DATA   = 4'd0;
  localparam logic [3:0] OFF_STATUS = 4'd4;
  localparam logic [3:0] OFF_MODE   = 4'd8;
  localparam logic [3:0] OFF_CTRL   = 4'd10;
  localparam logic [3:0] OFF_BAUD   = 4'd14;

  // Access sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // Configuration register indexes
  localparam logic CFG_PAD_PRESENT  = 1'b0;
  localparam logic CFG_CARD_PRESENT = 1'b1;

  // Control bits
  localparam int C_TXEN = 0;
  localparam int C_JOUT = 1;
  localparam int C_RXEN = 2;
  localparam int C_ACKN = 4;
  localparam int C_ACIE = 12;
  localparam int C_SLOT = 13;

  // Status bits and the acknowledge clear mask
  localparam int S_ACK = 7;
  localparam int S_IRQ = 9;
  localparam logic [15:0] STAT_ACK_CLR_MASK = 16'hfdc7;
  localparam logic [15:0] STAT_READ_SET     = 16'h0007;

  // Device select bytes
  localparam logic [15:0] BYTE_PAD_SEL  = 16'h0001;
  localparam logic [7:0]  BYTE_CARD_SEL = 8'h81;

  // Device operations reported with each result
  localparam logic [2:0] OP_NONE       = 3'd0;
  localparam logic [2:0] OP_PAD_WRITE  = 3'd1;
  localparam logic [2:0] OP_PAD_READ   = 3'd2;
  localparam logic [2:0] OP_CARD_XCHG  = 3'd3;
  localparam logic [2:0] OP_CARD_RESET = 3'd4;

  // Countdown width and default delays
  localparam int CNT_W                = 12;
  localparam int PAD_IRQ_DELAY_DEF    = 512;
  localparam int CARD_ACK_DELAY_DEF   = 1024;

  // Device selected in a slot
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_CARD = 2'd2
  } sel_t;

endpackage

FILE: rtl/pad_card_serial_port.sv
// Pad/card serial port: register file, slot selection and ack countdown.
// Depends on pcsp_pkg.
//
// Requests pass through an input register, then a result register, one per
// cycle while out_stall is low; the state update of a request is done as it
// moves from the input register to the result register. Reset (rst_n low,
// synchronous) clears the valid flags, control/status/mode/baud, selections,
// the card answer latch, pending flags, the countdown and the presence bits.
module pad_card_serial_port
  import pcsp_pkg::*;
#(
  parameter int PAD_IRQ_DELAY  = PAD_IRQ_DELAY_DEF,
  parameter int CARD_ACK_DELAY = CARD_ACK_DELAY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_reg_offset,
  input  logic [1:0]  in_access_size,
  input  logic [15:0] in_wdata,
  input  logic [15:0] in_tick_cycles,
  input  logic [7:0]  in_dev_answer,
  input  logic        in_dev_more,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rdata,
  output logic        out_irq_pulse,
  output logic [2:0]  out_dev_op,
  output logic        out_dev_slot,
  output logic [7:0]  out_dev_byte,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  localparam logic [CNT_W-1:0] PAD_DLY  = CNT_W'(PAD_IRQ_DELAY);
  localparam logic [CNT_W-1:0] CARD_DLY = CNT_W'(CARD_ACK_DELAY);

  // Input register
  logic        in_vld_r;
  logic [1:0]  req_r;
  logic [3:0]  off_r;
  logic [1:0]  size_r;
  logic [15:0] wdata_r;
  logic [15:0] tick_r;
  logic [7:0]  ans_r;
  logic        more_r;

  // Block state
  logic [15:0]      ctrl_r, ctrl_nxt;
  logic [15:0]      stat_r, stat_nxt;
  logic [15:0]      mode_r, mode_nxt;
  logic [15:0]      baud_r, baud_nxt;
  sel_t             sel_r [2];
  sel_t             sel_nxt [2];
  logic [7:0]       cans_r, cans_nxt;
  logic             cfull_r, cfull_nxt;
  logic             irqp_r, irqp_nxt;
  logic             ackp_r, ackp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       pad_r, card_r;

  // Result register
  logic        out_vld_r;
  logic [31:0] rdata_r, rdata_nxt;
  logic        irq_r, irq_nxt;
  logic [2:0]  op_r, op_nxt;
  logic        slot_r, slot_nxt;
  logic [7:0]  byte_r, byte_nxt;

  logic out_free;
  logic adv;

  // Handshake: advance when the result register is empty or being drained
  assign out_free  = !out_vld_r || !out_stall;
  assign adv       = in_vld_r && out_free;
  assign in_stall  = in_vld_r && !out_free;
  assign cfg_ready = 1'b1;

  // Capture requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      req_r   <= in_req_type;
      off_r   <= in_reg_offset;
      size_r  <= in_access_size;
      wdata_r <= in_wdata;
      tick_r  <= in_tick_cycles;
      ans_r   <= in_dev_answer;
      more_r  <= in_dev_more;
    end
  end

  // Compute the next state and the result of the registered request
  always_comb begin
    logic [31:0] rmask;
    logic [31:0] v;
    logic [15:0] w;
    logic [15:0] c;
    logic        slot;
    logic        old;
    logic        pad_here;
    logic        card_here;
    logic        xchg;
    sel_t        sel;

    ctrl_nxt   = ctrl_r;
    stat_nxt   = stat_r;
    mode_nxt   = mode_r;
    baud_nxt   = baud_r;
    sel_nxt[0] = sel_r[0];
    sel_nxt[1] = sel_r[1];
    cans_nxt   = cans_r;
    cfull_nxt  = cfull_r;
    irqp_nxt   = irqp_r;
    ackp_nxt   = ackp_r;
    cnt_nxt    = cnt_r;
    rdata_nxt  = '0;
    irq_nxt    = 1'b0;
    op_nxt     = OP_NONE;
    slot_nxt   = 1'b0;
    byte_nxt   = '0;

    slot      = ctrl_r[C_SLOT];
    old       = ctrl_r[C_SLOT];
    sel       = sel_r[slot];
    pad_here  = pad_r[slot];
    card_here = card_r[slot];
    xchg      = 1'b0;
    v         = '0;
    c         = '0;

    case (size_r)
      SIZE_BYTE: rmask = 32'h0000_00ff;
      SIZE_HALF: rmask = 32'h0000_ffff;
      default:   rmask = 32'hffff_ffff;
    endcase
    w = (size_r == SIZE_BYTE) ? {8'h00, wdata_r[7:0]} : wdata_r;

    case (req_r)
      REQ_READ: begin
        case (off_r)
          OFF_DATA: begin
            if (cfull_r) begin
              cfull_nxt = 1'b0;
              v = {24'h0, cans_r};
            end else if (sel != SEL_PAD && sel != SEL_CARD) begin
              v = 32'hffff_ffff;
            end else if (!ctrl_r[C_JOUT] && !ctrl_r[C_RXEN]) begin
              v = 32'hffff_ffff;
            end else if (sel == SEL_PAD) begin
              if (!pad_here) begin
                sel_nxt[slot] = SEL_NONE;
                v = 32'hffff_ffff;
              end else begin
                op_nxt   = OP_PAD_READ;
                slot_nxt = slot;
                if (!more_r) sel_nxt[slot] = SEL_NONE;
                v = {24'h0, ans_r};
              end
            end else begin
              if (!card_here) sel_nxt[slot] = SEL_NONE;
              v = 32'hffff_ffff;
            end
          end
          OFF_STATUS: begin
            v = {16'h0, stat_r | STAT_READ_SET};
            stat_nxt[S_ACK] = 1'b0;
          end
          OFF_MODE: v = {16'h0, mode_r};
          OFF_CTRL: v = {16'h0, ctrl_r};
          OFF_BAUD: v = {16'h0, baud_r};
          default:  v = '0;
        endcase
        rdata_nxt = v & rmask;
      end

      REQ_WRITE: begin
        case (off_r)
          OFF_DATA: begin
            if (ctrl_r[C_TXEN]) begin
              cfull_nxt = 1'b0;
              if (sel != SEL_PAD && sel != SEL_CARD) begin
                // nothing selected: the first byte picks the device
                sel_nxt[slot] = SEL_NONE;
                if (w == BYTE_PAD_SEL) begin
                  sel_nxt[slot] = SEL_PAD;
                  if (pad_here && ctrl_r[C_ACIE]) cnt_nxt = PAD_DLY;
                end else if (w == {8'h00, BYTE_CARD_SEL}) begin
                  sel_nxt[slot] = SEL_CARD;
                  xchg = card_here;
                end
              end else if (sel == SEL_CARD) begin
                if (!card_here) sel_nxt[slot] = SEL_NONE;
                else xchg = 1'b1;
              end else if (!pad_here) begin
                sel_nxt[slot] = SEL_NONE;
              end else begin
                op_nxt   = OP_PAD_WRITE;
                slot_nxt = slot;
                byte_nxt = w[7:0];
                if (!more_r) sel_nxt[slot] = SEL_NONE;
                if (ctrl_r[C_ACIE]) begin
                  irqp_nxt = 1'b1;
                  cnt_nxt  = PAD_DLY;
                end
              end
              // card byte exchange: latch the answer, arm the ack countdown if more follows and ACIE is set
              if (xchg) begin
                op_nxt    = OP_CARD_XCHG;
                slot_nxt  = slot;
                byte_nxt  = w[7:0];
                cans_nxt  = ans_r;
                cfull_nxt = 1'b1;
                if (more_r) begin
                  if (ctrl_r[C_ACIE]) begin
                    irqp_nxt = 1'b1;
                    ackp_nxt = 1'b1;
                    cnt_nxt  = (w[7:0] == BYTE_CARD_SEL) ? PAD_DLY : CARD_DLY;
                  end
                end else begin
                  sel_nxt[slot] = SEL_NONE;
                end
              end
            end
          end
          OFF_MODE: mode_nxt = w;
          OFF_CTRL: begin
            c = w;
            if (!c[C_JOUT]) begin
              c[C_SLOT]    = 1'b0;
              sel_nxt[old] = SEL_NONE;
              if (card_r[old]) begin
                op_nxt   = OP_CARD_RESET;
                slot_nxt = old;
              end
            end
            if (c[C_ACKN]) begin
              stat_nxt  = stat_r & STAT_ACK_CLR_MASK;
              c[C_ACKN] = 1'b0;
            end
            ctrl_nxt = c;
          end
          OFF_BAUD: baud_nxt = w;
          default: ;
        endcase
      end

      REQ_TICK: begin
        // run the countdown down; expiry raises the interrupt and saturates
        if (cnt_r != '0) begin
          if (tick_r >= {{(16-CNT_W){1'b0}}, cnt_r}) begin
            irq_nxt = 1'b1;
            if (irqp_r) begin
              stat_nxt[S_IRQ] = 1'b1;
              irqp_nxt = 1'b0;
            end
            if (ackp_r) begin
              stat_nxt[S_ACK] = 1'b1;
              ackp_nxt = 1'b0;
            end
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_r - tick_r[CNT_W-1:0];
          end
        end
      end

      default: ;
    endcase
  end

  // Update state on each request that moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      stat_r   <= '0;
      mode_r   <= '0;
      baud_r   <= '0;
      sel_r[0] <= SEL_NONE;
      sel_r[1] <= SEL_NONE;
      cans_r   <= '0;
      cfull_r  <= 1'b0;
      irqp_r   <= 1'b0;
      ackp_r   <= 1'b0;
      cnt_r    <= '0;
    end else if (adv) begin
      ctrl_r   <= ctrl_nxt;
      stat_r   <= stat_nxt;
      mode_r   <= mode_nxt;
      baud_r   <= baud_nxt;
      sel_r[0] <= sel_nxt[0];
      sel_r[1] <= sel_nxt[1];
      cans_r   <= cans_nxt;
      cfull_r  <= cfull_nxt;
      irqp_r   <= irqp_nxt;
      ackp_r   <= ackp_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r  <= '0;
      card_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAD_PRESENT:  pad_r  <= cfg_data;
        CFG_CARD_PRESENT: card_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
    if (adv) begin
      rdata_r <= rdata_nxt;
      irq_r   <= irq_nxt;
      op_r    <= op_nxt;
      slot_r  <= slot_nxt;
      byte_r  <= byte_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_rdata     = rdata_r;
  assign out_irq_pulse = irq_r;
  assign out_dev_op    = op_r;
  assign out_dev_slot  = slot_r;
  assign out_dev_byte  = byte_r;

endmodule

FILE: test/tb.sv
// Testbench for pad_card_serial_port: directed table then paced random requests,
// every result checked against the table's fixed value or a behavioral model kept here.
// Depends on pcsp_pkg and the pad_card_serial_port RTL.
module tb
  import pcsp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] SIZE_WORD  = 2'd2;
  localparam logic [1:0] SIZE_WIDE  = 2'd3;   // treated as a word
  localparam logic [1:0] REQ_NOP    = 2'd3;   // unused request type
  localparam logic [3:0] OFF_HOLE   = 4'd15;  // no register behind it
  localparam int         N_DIRECTED = 25;
  localparam int         N_PHASES   = 8;
  localparam int         PHASE_REQS = 94;
  localparam int         STUCK_MAX  = 3000;
  localparam logic [11:0] PAD_CNT  = 12'(PAD_IRQ_DELAY_DEF);
  localparam logic [11:0] CARD_CNT = 12'(CARD_ACK_DELAY_DEF);

  // presence settings per random phase, extremes included
  localparam logic [1:0] PH_PADS  [N_PHASES] = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd1};
  localparam logic [1:0] PH_CARDS [N_PHASES] = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd3, 2'd1};

  typedef struct packed {
    logic [1:0]  req;
    logic [3:0]  ofs;
    logic [1:0]  size;
    logic [15:0] wdata;
    logic [15:0] tick;
    logic [7:0]  answer;
    logic        more;
  } port_req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
    logic [2:0]  op;
    logic        slot;
    logic [7:0]  dbyte;
  } port_res_t;

  typedef struct packed {
    port_req_t item;
    logic      fixed;
    port_res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [3:0]  in_reg_offset;
  logic [1:0]  in_access_size;
  logic [15:0] in_wdata;
  logic [15:0] in_tick_cycles;
  logic [7:0]  in_dev_answer;
  logic        in_dev_more;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_rdata;
  logic        out_irq_pulse;
  logic [2:0]  out_dev_op;
  logic        out_dev_slot;
  logic [7:0]  out_dev_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [1:0]  cfg_data;

  // model state of the port
  logic [15:0] ctrl_q, stat_q, mode_q, baud_q;
  sel_t        sel_q [2];
  logic [7:0]  card_ans_q;
  logic        card_full_q, irq_pend_q, ack_pend_q;
  logic [11:0] countdown_q;
  logic [1:0]  pad_mask, card_mask;

  port_res_t due_results [$];
  int send_pct = 0;
  int stall_pct = 0;
  int n_bad = 0;
  int n_seen = 0;
  int n_reads = 0, n_writes = 0, n_ticks = 0, n_irqs = 0, n_dev_ops = 0;
  int stuck_cycles = 0;

  pad_card_serial_port dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_reg_offset(in_reg_offset),
    .in_access_size(in_access_size), .in_wdata(in_wdata),
    .in_tick_cycles(in_tick_cycles), .in_dev_answer(in_dev_answer),
    .in_dev_more(in_dev_more),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_rdata(out_rdata), .out_irq_pulse(out_irq_pulse),
    .out_dev_op(out_dev_op), .out_dev_slot(out_dev_slot),
    .out_dev_byte(out_dev_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // clear the model to its post-reset state
  function automatic void sio_reset();
    ctrl_q = '0;
    stat_q = '0;
    mode_q = '0;
    baud_q = '0;
    sel_q[0] = SEL_NONE;
    sel_q[1] = SEL_NONE;
    card_ans_q = '0;
    card_full_q = 1'b0;
    irq_pend_q = 1'b0;
    ack_pend_q = 1'b0;
    countdown_q = '0;
    pad_mask = '0;
    card_mask = '0;
  endfunction

  // exchange one byte with the card in a slot and latch its answer
  function automatic void card_xchg(input logic slot, input logic [15:0] w,
                                    input port_req_t it, inout port_res_t res);
    res.op = OP_CARD_XCHG;
    res.slot = slot;
    res.dbyte = w[7:0];
    card_ans_q = it.answer;
    card_full_q = 1'b1;
    if (it.more) begin
      if (ctrl_q[C_ACIE]) begin
        irq_pend_q = 1'b1;
        ack_pend_q = 1'b1;
        countdown_q = (w[7:0] == BYTE_CARD_SEL) ? PAD_CNT : CARD_CNT;
      end
    end else begin
      sel_q[slot] = SEL_NONE;
    end
  endfunction

  // compute the result of one request and advance the model
  function automatic port_res_t sio_predict(input port_req_t it);
    port_res_t   res;
    logic [31:0] rmask;
    logic [31:0] v;
    logic [15:0] w;
    logic        slot;
    logic        old_slot;
    sel_t        sel;
    res = '0;
    v = '0;
    slot = ctrl_q[C_SLOT];
    sel = sel_q[slot];
    rmask = (it.size == SIZE_BYTE) ? 32'h0000_00ff :
            (it.size == SIZE_HALF) ? 32'h0000_ffff : 32'hffff_ffff;
    w = (it.size == SIZE_BYTE) ? {8'h00, it.wdata[7:0]} : it.wdata;
    case (it.req)
      REQ_READ: begin
        case (it.ofs)
          OFF_DATA: begin
            if (card_full_q) begin
              card_full_q = 1'b0;
              v = {24'h0, card_ans_q};
            end else if (sel == SEL_NONE) begin
              v = '1;
            end else if (!ctrl_q[C_JOUT] && !ctrl_q[C_RXEN]) begin
              v = '1;
            end else if (sel == SEL_PAD) begin
              if (!pad_mask[slot]) begin
                sel_q[slot] = SEL_NONE;
                v = '1;
              end else begin
                res.op = OP_PAD_READ;
                res.slot = slot;
                if (!it.more) sel_q[slot] = SEL_NONE;
                v = {24'h0, it.answer};
              end
            end else begin
              if (!card_mask[slot]) sel_q[slot] = SEL_NONE;
              v = '1;
            end
          end
          OFF_STATUS: begin
            v = {16'h0, stat_q | STAT_READ_SET};
            stat_q[S_ACK] = 1'b0;
          end
          OFF_MODE: v = {16'h0, mode_q};
          OFF_CTRL: v = {16'h0, ctrl_q};
          OFF_BAUD: v = {16'h0, baud_q};
          default: v = '0;
        endcase
        res.rdata = v & rmask;
      end
      REQ_WRITE: begin
        case (it.ofs)
          OFF_DATA: begin
            if (ctrl_q[C_TXEN]) begin
              card_full_q = 1'b0;
              if (sel == SEL_NONE) begin
                // select byte: picks the device, only the card hears it
                if (w == BYTE_PAD_SEL) begin
                  sel_q[slot] = SEL_PAD;
                  if (pad_mask[slot] && ctrl_q[C_ACIE]) countdown_q = PAD_CNT;
                end else if (w == {8'h00, BYTE_CARD_SEL}) begin
                  sel_q[slot] = SEL_CARD;
                  if (card_mask[slot]) card_xchg(slot, w, it, res);
                end
              end else if (sel == SEL_CARD) begin
                if (!card_mask[slot]) sel_q[slot] = SEL_NONE;
                else card_xchg(slot, w, it, res);
              end else if (!pad_mask[slot]) begin
                sel_q[slot] = SEL_NONE;
              end else begin
                res.op = OP_PAD_WRITE;
                res.slot = slot;
                res.dbyte = w[7:0];
                if (!it.more) sel_q[slot] = SEL_NONE;
                if (ctrl_q[C_ACIE]) begin
                  irq_pend_q = 1'b1;
                  countdown_q = PAD_CNT;
                end
              end
            end
          end
          OFF_MODE: mode_q = w;
          OFF_CTRL: begin
            old_slot = ctrl_q[C_SLOT];
            ctrl_q = w;
            // dropping select-out releases the slot and resets its card
            if (!ctrl_q[C_JOUT]) begin
              ctrl_q[C_SLOT] = 1'b0;
              sel_q[old_slot] = SEL_NONE;
              if (card_mask[old_slot]) begin
                res.op = OP_CARD_RESET;
                res.slot = old_slot;
              end
            end
            if (ctrl_q[C_ACKN]) begin
              stat_q = stat_q & STAT_ACK_CLR_MASK;
              ctrl_q[C_ACKN] = 1'b0;
            end
          end
          OFF_BAUD: baud_q = w;
          default: ;
        endcase
      end
      REQ_TICK: begin
        // run the countdown down, saturating at zero on expiry
        if (countdown_q != 0) begin
          if (it.tick >= {4'h0, countdown_q}) begin
            res.irq = 1'b1;
            if (irq_pend_q) begin
              stat_q[S_IRQ] = 1'b1;
              irq_pend_q = 1'b0;
            end
            if (ack_pend_q) begin
              stat_q[S_ACK] = 1'b1;
              ack_pend_q = 1'b0;
            end
            countdown_q = '0;
          end else begin
            countdown_q = countdown_q - it.tick[11:0];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // draw a request, weighted toward select / exchange / tick sequences
  function automatic port_req_t rand_request();
    port_req_t it;
    int        pick;
    it.req = REQ_READ;
    it.ofs = OFF_DATA;
    it.size = SIZE_BYTE;
    it.wdata = 16'($urandom);
    it.tick = 16'($urandom);
    it.answer = 8'($urandom);
    it.more = ($urandom_range(9) < 7);
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.req = REQ_WRITE;
      case ($urandom_range(7))
        0, 1: it.wdata = BYTE_PAD_SEL;
        2, 3: it.wdata = {8'h00, BYTE_CARD_SEL};
        4: ;
        default: it.wdata = {8'h00, it.wdata[7:0]};
      endcase
      if ($urandom_range(7) == 0) it.size = 2'($urandom);
    end else if (pick < 50) begin
      if ($urandom_range(3) == 0) it.size = 2'($urandom);
    end else if (pick < 65) begin
      it.req = REQ_TICK;
      case ($urandom_range(4))
        0, 1: it.tick = 16'($urandom_range(600));
        2: it.tick = 16'($urandom_range(1100));
        3: it.tick = 16'h0000;
        default: ;
      endcase
    end else if (pick < 75) begin
      it.ofs = OFF_STATUS;
      it.size = 2'($urandom);
    end else if (pick < 85) begin
      it.req = REQ_WRITE;
      it.ofs = OFF_CTRL;
      it.size = ($urandom_range(7) == 0) ? 2'($urandom) : SIZE_HALF;
      if ($urandom_range(3) != 0) begin
        it.wdata = '0;
        it.wdata[C_TXEN] = ($urandom_range(9) != 0);
        it.wdata[C_JOUT] = ($urandom_range(9) != 0);
        it.wdata[C_RXEN] = 1'($urandom_range(1));
        it.wdata[C_ACKN] = ($urandom_range(3) == 0);
        it.wdata[C_ACIE] = ($urandom_range(3) != 0);
        it.wdata[C_SLOT] = 1'($urandom_range(1));
      end
    end else begin
      // noise: any request type, offset and size
      it.req = 2'($urandom);
      it.ofs = 4'($urandom);
      it.size = 2'($urandom);
    end
    return it;
  endfunction

  // present one request, hold it until accepted, queue its result
  task automatic drive_request(input port_req_t it, input logic fixed,
                               input port_res_t fixed_res);
    port_res_t want;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.req;
    in_reg_offset <= it.ofs;
    in_access_size <= it.size;
    in_wdata <= it.wdata;
    in_tick_cycles <= it.tick;
    in_dev_answer <= it.answer;
    in_dev_more <= it.more;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = sio_predict(it);
    if (fixed) want = fixed_res;
    due_results.push_back(want);
    n_reads += (it.req == REQ_READ);
    n_writes += (it.req == REQ_WRITE);
    n_ticks += (it.req == REQ_TICK);
    n_irqs += want.irq;
    n_dev_ops += (want.op != OP_NONE);
    @(negedge clk);
  endtask

  // drop valid and wait until every queued result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write both presence registers
  task automatic set_presence(input logic [1:0] pads, input logic [1:0] cards);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? CFG_PAD_PRESENT : CFG_CARD_PRESENT;
      cfg_data <= (i == 0) ? pads : cards;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (i == 0) pad_mask = pads;
      else card_mask = cards;
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // randomize receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // check each accepted result against the oldest queued one
  always @(posedge clk) begin
    port_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_seen++;
      if (due_results.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("tb: result %0d arrived with nothing outstanding", n_seen);
      end else begin
        want = due_results.pop_front();
        if (out_rdata !== want.rdata || out_irq_pulse !== want.irq ||
            out_dev_op !== want.op || out_dev_slot !== want.slot ||
            out_dev_byte !== want.dbyte) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"tb: result %0d want rdata %h irq %b op %0d slot %b byte %h,",
                      " got %h %b %0d %b %h"},
                     n_seen, want.rdata, want.irq, want.op, want.slot, want.dbyte,
                     out_rdata, out_irq_pulse, out_dev_op, out_dev_slot, out_dev_byte);
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_MAX) begin
      $display("tb: no handshake for %0d cycles, %0d results outstanding",
               STUCK_MAX, due_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tbl [N_DIRECTED];
    // extremes, error codes and one pass through pad and card sequences
    dir_tbl = '{
      '{'{REQ_READ,  OFF_STATUS, SIZE_WORD, 16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b1,
        '{32'h0000_0007, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_READ,  OFF_CTRL,   SIZE_HALF, 16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b1,
        '{32'h0000_0000, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_READ,  OFF_DATA,   SIZE_BYTE, 16'h0000, 16'h0000, 8'h5a, 1'b1}, 1'b1,
        '{32'h0000_00ff, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_READ,  OFF_HOLE,   SIZE_WORD, 16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b1,
        '{32'h0000_0000, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_READ,  OFF_DATA,   SIZE_WIDE, 16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b1,
        '{32'hffff_ffff, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_NOP,   OFF_DATA,   SIZE_WORD, 16'hffff, 16'hffff, 8'hff, 1'b1}, 1'b1,
        '{32'h0000_0000, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_WRITE, OFF_BAUD,   SIZE_WORD, 16'hffff, 16'h0000, 8'h00, 1'b0}, 1'b1,
        '{32'h0000_0000, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_READ,  OFF_BAUD,   SIZE_BYTE, 16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b1,
        '{32'h0000_00ff, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_WRITE, OFF_MODE,   SIZE_BYTE, 16'hffff, 16'h0000, 8'h00, 1'b0}, 1'b1,
        '{32'h0000_0000, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_READ,  OFF_MODE,   SIZE_WIDE, 16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b1,
        '{32'h0000_00ff, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_WRITE, OFF_STATUS, SIZE_WORD, 16'hffff, 16'h0000, 8'h00, 1'b0}, 1'b1,
        '{32'h0000_0000, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_WRITE, OFF_CTRL,   SIZE_HALF, 16'h1003, 16'h0000, 8'h00, 1'b0}, 1'b1,
        '{32'h0000_0000, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_WRITE, OFF_DATA,   SIZE_BYTE, 16'h0001, 16'h0000, 8'h00, 1'b1}, 1'b1,
        '{32'h0000_0000, 1'b0, OP_NONE, 1'b0, 8'h00}},
      '{'{REQ_WRITE, OFF_DATA,   SIZE_BYTE, 16'h0042, 16'h0000, 8'h00, 1'b1}, 1'b0, '0},
      '{'{REQ_TICK,  OFF_DATA,   SIZE_BYTE, 16'h0000, 16'h01ff, 8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_TICK,  OFF_DATA,   SIZE_BYTE, 16'h0000, 16'h0001, 8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_READ,  OFF_STATUS, SIZE_HALF, 16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_READ,  OFF_DATA,   SIZE_BYTE, 16'h0000, 16'h0000, 8'ha5, 1'b0}, 1'b0, '0},
      '{'{REQ_WRITE, OFF_CTRL,   SIZE_HALF, 16'h3013, 16'h0000, 8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_WRITE, OFF_DATA,   SIZE_BYTE, 16'h0081, 16'h0000, 8'h99, 1'b1}, 1'b0, '0},
      '{'{REQ_WRITE, OFF_DATA,   SIZE_HALF, 16'h00ff, 16'h0000, 8'h33, 1'b0}, 1'b0, '0},
      '{'{REQ_READ,  OFF_DATA,   SIZE_WORD, 16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_TICK,  OFF_DATA,   SIZE_BYTE, 16'h0000, 16'hffff, 8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_READ,  OFF_STATUS, SIZE_WORD, 16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_WRITE, OFF_CTRL,   SIZE_HALF, 16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b0, '0}
    };

    // hold all inputs known through reset
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_READ;
    in_reg_offset = OFF_DATA;
    in_access_size = SIZE_BYTE;
    in_wdata = '0;
    in_tick_cycles = '0;
    in_dev_answer = '0;
    in_dev_more = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PAD_PRESENT;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    sio_reset();

    // directed table, both slots populated
    set_presence(2'b11, 2'b11);
    for (int r = 0; r < N_DIRECTED; r++)
      drive_request(dir_tbl[r].item, dir_tbl[r].fixed, dir_tbl[r].res);
    wait_drained();

    // random phases: rotate pacing and presence
    for (int p = 0; p < N_PHASES; p++) begin
      send_pct = (p % 4 == 1) ? 86 : (p % 4 == 3) ? 32 : 0;
      stall_pct = (p % 4 == 2) ? 86 : (p % 4 == 3) ? 32 : 0;
      set_presence(PH_PADS[p], PH_CARDS[p]);
      for (int k = 0; k < PHASE_REQS; k++)
        drive_request(rand_request(), 1'b0, '0);
      wait_drained();
    end
    stall_pct = 0;
    repeat (8) @(posedge clk);

    $display("tb: %0d requests (%0d reads, %0d writes, %0d ticks) over %0d phases",
             n_reads + n_writes + n_ticks, n_reads, n_writes, n_ticks, N_PHASES + 1);
    $display("tb: %0d results checked, %0d interrupt pulses, %0d device ops, %0d mismatches",
             n_seen, n_irqs, n_dev_ops, n_bad);
    if (due_results.size() != 0)
      $display("tb: %0d results never arrived", due_results.size());
    if (n_bad == 0 && due_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: pad_card_serial_port.f
rtl/pcsp_pkg.sv
rtl/pad_card_serial_port.sv
test/tb.sv
